>>> hdl/stp_pkg.sv
// Shared types, constants and the duty lookup builder for the servo profiler.
// Used by stp_front, stp_back and the top level; depends on nothing.
package stp_pkg;

  localparam int unsigned ChannelsDef = 5;
  localparam int unsigned DutyBitsDef = 14;
  localparam int unsigned FracBitsDef = 8;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;

  localparam logic [7:0] AngleMaxDeg = 8'd180;
  localparam logic [7:0] GoalReset   = 8'd90;

  localparam int AngleMax = 180;
  localparam int PulseMin = 500;
  localparam int PulseMax = 2500;
  localparam int PeriodUs = 20000;

  localparam logic [10:0] MaxVelReset = 11'd1024;
  localparam logic [9:0]  AccelReset  = 10'd128;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CfgMaxVelocity  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAcceleration = 1'd1;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] ch;
    logic [7:0] goal;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  ch;
    logic [7:0]  angle;
    logic [13:0] duty;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_SQRT,
    BK_STEP,
    BK_EMIT,
    BK_FLUSH
  } back_state_e;

  typedef logic [255:0][15:0] duty_lut_t;

  function automatic duty_lut_t duty_table(int duty_bits);
    duty_lut_t t;
    int        pulse;
    t = '0;
    for (int d = 0; d < 256; d++) begin
      pulse = d * (PulseMax - PulseMin) / AngleMax + PulseMin;
      t[d] = 16'((pulse * ((1 << duty_bits) - 1)) / PeriodUs);
    end
    return t;
  endfunction

endpackage

>>> hdl/stp_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// Stand-alone; no package dependency.
module stp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/stp_front.sv
// Front end: accepts items, saturates goals, drops out-of-range sets, queues commands.
// Depends on stp_pkg and stp_fifo.
module stp_front #(
  parameter int unsigned CHANNELS = stp_pkg::ChannelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          kind_i,
  input  logic [2:0]    channel_i,
  input  logic [7:0]    target_angle_i,
  output logic          cmd_valid_o,
  output stp_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  stp_pkg::cmd_t                   cmd_in;
  logic                            keep;
  logic                            q_empty;
  logic [$bits(stp_pkg::cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.kind = stp_pkg::cmd_kind_e'(kind_i);
    cmd_in.ch   = channel_i;
    cmd_in.goal = (target_angle_i > stp_pkg::AngleMaxDeg) ? stp_pkg::AngleMaxDeg
                                                           : target_angle_i;
    keep = (cmd_in.kind == stp_pkg::CMD_TICK) ||
           ({29'd0, channel_i} < 32'(CHANNELS));
  end

  stp_fifo #(
    .W    ($bits(stp_pkg::cmd_t)),
    .DEPTH(stp_pkg::CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && keep),
    .full_o (full_o),
    .wdata_i(cmd_in),
    .pop_i  (cmd_pop_i),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = stp_pkg::cmd_t'(q_rdata);

endmodule

>>> hdl/stp_isqrt.sv
// Iterative integer square root, one result bit per cycle, truncating.
// Stand-alone; no package dependency.
module stp_isqrt #(
  parameter int unsigned RW = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] op_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned SW = 2 * RW;
  localparam int unsigned CW = $clog2(RW);

  logic [SW-1:0] x_q, x_d;
  logic [RW+1:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, x_q[SW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = op_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d    = {x_q[SW-3:0], 2'b00};
      rem_d  = ge ? diff[RW+1:0] : rem_sh[RW+1:0];
      root_d = {root_q[RW-2:0], ge};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hdl/stp_back.sv
// Back end: per-channel state and the tick sequencer (ramp, cap, integrate, snap, duty).
// Depends on stp_pkg and stp_isqrt.
module stp_back #(
  parameter int unsigned CHANNELS  = stp_pkg::ChannelsDef,
  parameter int unsigned DUTY_BITS = stp_pkg::DutyBitsDef,
  parameter int unsigned FRAC_BITS = stp_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [10:0]   max_vel_i,
  input  logic [9:0]    accel_i,
  input  logic          cmd_valid_i,
  input  stp_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_push_o,
  output stp_pkg::res_t out_data_o,
  input  logic          out_full_i
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW   = 8 + FRAC_BITS;
  localparam int unsigned RW   = (20 + FRAC_BITS) / 2;
  localparam int unsigned SW   = 2 * RW;
  localparam int unsigned Thresh = (1 << FRAC_BITS) / 10;
  localparam logic [PW-1:0] PosMax   = PW'(stp_pkg::AngleMax << FRAC_BITS);
  localparam logic [PW-1:0] PosReset = PW'(90 << FRAC_BITS);
  localparam stp_pkg::duty_lut_t DutyLut = stp_pkg::duty_table(DUTY_BITS);

  stp_pkg::back_state_e state_q, state_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic                 pend_vld_q, pend_vld_d;

  logic [PW-1:0]        pos_q  [CHANNELS];
  logic signed [11:0]   vel_q  [CHANNELS];
  logic [7:0]           goal_q [CHANNELS];

  logic [PW-1:0]        ad_q, ad_d;
  logic                 up_q, up_d;
  logic [PW-1:0]        tgt_q, tgt_d;
  stp_pkg::res_t        res_q, res_d;
  stp_pkg::res_t        pend_q, pend_d;

  logic                 st_we;
  logic [PW-1:0]        st_pos;
  logic signed [11:0]   st_vel;
  logic                 goal_we;

  logic [PW-1:0]        pos_cur;
  logic [PW-1:0]        tgt_cur;
  logic signed [PW:0]   dd;
  logic [PW-1:0]        ad_cur;

  logic                 sq_start;
  logic                 sq_done;
  logic [RW-1:0]        sq_root;
  logic [18+FRAC_BITS:0] prod;

  logic [10:0]          sp;
  logic signed [12:0]   vx, a13, sp13, v;
  logic signed [PW+1:0] np, rem;
  logic [PW-1:0]        pos_n;
  logic [PW+1:0]        rem_abs;
  logic [12:0]          av;
  logic [7:0]           deg;
  logic                 last_ch;

  // Datapath for the current channel
  always_comb begin
    pos_cur = pos_q[ch_q];
    tgt_cur = {goal_q[ch_q], {FRAC_BITS{1'b0}}};
    dd      = $signed({1'b0, tgt_cur}) - $signed({1'b0, pos_cur});
    ad_cur  = dd[PW] ? PW'(-dd) : PW'(dd);

    prod = {accel_i, 1'b0} * ad_q;

    sp   = (sq_root > RW'(max_vel_i)) ? max_vel_i : sq_root[10:0];
    vx   = 13'(vel_q[ch_q]);
    a13  = $signed({3'b000, accel_i});
    sp13 = $signed({2'b00, sp});
    if (up_q) begin
      v = vx + a13;
      if (v > sp13) begin
        v = sp13;
      end
    end else begin
      v = vx - a13;
      if (v < -sp13) begin
        v = -sp13;
      end
    end
    np = $signed({2'b00, pos_cur}) + (PW+2)'(v);
    if (np < 0) begin
      pos_n = '0;
    end else if (np > $signed({2'b00, PosMax})) begin
      pos_n = PosMax;
    end else begin
      pos_n = np[PW-1:0];
    end
    rem     = $signed({2'b00, tgt_q}) - $signed({2'b00, pos_n});
    rem_abs = rem[PW+1] ? (PW+2)'(-rem) : (PW+2)'(rem);
    av      = v[12] ? 13'(-v) : 13'(v);
    if (rem_abs < (PW+2)'(av)) begin
      pos_n = tgt_q;
      v     = '0;
    end
    deg = pos_n[PW-1:FRAC_BITS];
  end

  stp_isqrt #(
    .RW(RW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .op_i   (SW'(prod)),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  assign last_ch = (ch_q == CH_W'(CHANNELS - 1));

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    ad_d       = ad_q;
    up_d       = up_q;
    tgt_d      = tgt_q;
    res_d      = res_q;
    st_we      = 1'b0;
    st_pos     = pos_n;
    st_vel     = v[11:0];
    goal_we    = 1'b0;
    cmd_pop_o  = 1'b0;
    sq_start   = 1'b0;
    out_push_o = 1'b0;
    out_data_o = pend_q;
    unique case (state_q)
      stp_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == stp_pkg::CMD_SET) begin
            goal_we = 1'b1;
          end else begin
            ch_d    = '0;
            state_d = stp_pkg::BK_LOAD;
          end
        end
      end
      stp_pkg::BK_LOAD: begin
        tgt_d = tgt_cur;
        ad_d  = ad_cur;
        up_d  = !dd[PW];
        if (ad_cur <= PW'(Thresh)) begin
          st_we  = 1'b1;
          st_pos = tgt_cur;
          st_vel = '0;
          if (last_ch) begin
            state_d = stp_pkg::BK_FLUSH;
          end else begin
            ch_d = ch_q + CH_W'(1);
          end
        end else begin
          state_d = stp_pkg::BK_MUL;
        end
      end
      stp_pkg::BK_MUL: begin
        sq_start = 1'b1;
        state_d  = stp_pkg::BK_SQRT;
      end
      stp_pkg::BK_SQRT: begin
        if (sq_done) begin
          state_d = stp_pkg::BK_STEP;
        end
      end
      stp_pkg::BK_STEP: begin
        st_we       = 1'b1;
        res_d.ch    = 3'(ch_q);
        res_d.angle = deg;
        res_d.duty  = DutyLut[deg][13:0];
        res_d.last  = 1'b0;
        state_d     = stp_pkg::BK_EMIT;
      end
      stp_pkg::BK_EMIT: begin
        if (!(pend_vld_q && out_full_i)) begin
          out_push_o = pend_vld_q;
          pend_d     = res_q;
          pend_vld_d = 1'b1;
          if (last_ch) begin
            state_d = stp_pkg::BK_FLUSH;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = stp_pkg::BK_LOAD;
          end
        end
      end
      stp_pkg::BK_FLUSH: begin
        out_data_o.last = 1'b1;
        if (!pend_vld_q) begin
          state_d = stp_pkg::BK_IDLE;
        end else if (!out_full_i) begin
          out_push_o = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = stp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = stp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stp_pkg::BK_IDLE;
      ch_q       <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ch_q       <= ch_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]  <= PosReset;
        vel_q[i]  <= '0;
        goal_q[i] <= stp_pkg::GoalReset;
      end
    end else begin
      if (st_we) begin
        pos_q[ch_q] <= st_pos;
        vel_q[ch_q] <= st_vel;
      end
      if (goal_we) begin
        goal_q[CH_W'(cmd_i.ch)] <= cmd_i.goal;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q   <= ad_d;
    up_q   <= up_d;
    tgt_q  <= tgt_d;
    res_q  <= res_d;
    pend_q <= pend_d;
  end

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into a full queue");

  a_root_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == stp_pkg::BK_SQRT)
    else $error("root finished outside the wait state");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> state_q != stp_pkg::BK_IDLE)
    else $error("held result left behind at idle");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == stp_pkg::BK_LOAD |-> pos_cur <= PosMax)
    else $error("position out of range");
`endif

endmodule

>>> hdl/servo_trapezoid_profiler.sv
// Servo trapezoid profiler, top level: configuration registers, front, back, result queue.
// Depends on stp_pkg, stp_front, stp_back and stp_fifo.
//
// Usage:
//   Items enter through a queue-like port: an item is taken at a clock edge with
//   push high and full low. A set item (kind 1) stores a channel goal; a tick
//   item (kind 0) advances every channel one step. Results leave through a queue
//   port: the oldest result is on the result ports while empty is low and is
//   taken at an edge with pop high. last marks the final result of a tick.
//   Configuration (max velocity, acceleration) is written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while the block is idle.
// Sequencing:
//   A set item is handled in the back end's idle state. Per tick, a channel
//   inside the dead band is settled in the load state alone; a moving channel
//   passes through load, multiply, square root, step and emit, its square root
//   computed by the bit-per-cycle square root unit.
//   Each result is held until the next moving channel or the end of the tick,
//   so that last can be set on it.
// Reset: all channels at 90 degrees with zero velocity, queues empty.
// Stall: a full result queue holds the sequencer; the command queue keeps
//   taking items until it is full.
module servo_trapezoid_profiler #(
  parameter int unsigned CHANNELS  = stp_pkg::ChannelsDef,
  parameter int unsigned DUTY_BITS = stp_pkg::DutyBitsDef,
  parameter int unsigned FRAC_BITS = stp_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind_i,
  input  logic [2:0]                   channel_i,
  input  logic [7:0]                   target_angle_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [2:0]                   channel_res_o,
  output logic [7:0]                   angle_o,
  output logic [13:0]                  duty_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [stp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stp_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [10:0]                      max_vel_q;
  logic [9:0]                       accel_q;
  logic                             cmd_valid;
  stp_pkg::cmd_t                    cmd;
  logic                             cmd_pop;
  logic                             out_push;
  stp_pkg::res_t                    out_data;
  logic                             out_full;
  logic [$bits(stp_pkg::res_t)-1:0] out_rdata;
  stp_pkg::res_t                    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q <= stp_pkg::MaxVelReset;
      accel_q   <= stp_pkg::AccelReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == stp_pkg::CfgMaxVelocity) begin
        max_vel_q <= cfg_data_i[10:0];
      end
      if (cfg_idx_i == stp_pkg::CfgAcceleration) begin
        accel_q <= cfg_data_i[9:0];
      end
    end
  end

  stp_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .channel_i     (channel_i),
    .target_angle_i(target_angle_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  stp_back #(
    .CHANNELS (CHANNELS),
    .DUTY_BITS(DUTY_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_vel_i  (max_vel_q),
    .accel_i    (accel_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_push_o (out_push),
    .out_data_o (out_data),
    .out_full_i (out_full)
  );

  stp_fifo #(
    .W    ($bits(stp_pkg::res_t)),
    .DEPTH(stp_pkg::OutDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .full_o (out_full),
    .wdata_i(out_data),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(out_rdata)
  );

  assign res           = stp_pkg::res_t'(out_rdata);
  assign channel_res_o = res.ch;
  assign angle_o       = res.angle;
  assign duty_o        = res.duty;
  assign last_o        = res.last;

endmodule
